// ===== design/ghb_correlation_prefetcher_defines.svh =====
// Assertion macros used by the prefetcher checker.
`ifndef GHB_CORRELATION_PREFETCHER_DEFINES_SVH
`define GHB_CORRELATION_PREFETCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GHB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define GHB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ghb_pkg.sv =====
// Shared constants and types of the global-history-buffer prefetcher.
`default_nettype none

package ghb_pkg;

  // Cache block number width
  localparam int BLOCK_W = 58;

  // Default sizes and walk limits
  localparam int GHB_INDEX_SIZE       = 256;
  localparam int GHB_HISTORY_SIZE     = 256;
  localparam int GHB_GENERATION_COUNT = 4;
  localparam int GHB_WALK_WIDTH       = 4;
  localparam int GHB_WALK_DEPTH       = 4;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MISS  = 6'b000100,
    S_WIDE  = 6'b001000,
    S_DEEP0 = 6'b010000,
    S_DEEP1 = 6'b100000
  } ghb_state_t;

endpackage

`default_nettype wire

// ===== design/ghb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ghb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output      logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request; hold read data unless a read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/ghb_correlation_prefetcher.sv =====
// Top level of the global-history-buffer address-correlation prefetcher.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  cmd     | cmd_valid/cmd_ready, command, block_addr,      | in
//          | access_hit, is_load                            |
//  pf      | pf_valid/pf_ready, prefetch_block              | out
//
// A miss reads the index slot, then writes the index and history entries.
// A tick does nothing when the walk is idle; a deep step that continues a
// chain reads the older entry, then issues it; one that starts a new wide
// link first follows the link, as each dependent history read waits on the
// single read port. After reset a clearing pass over max(INDEX_SIZE,
// HISTORY_SIZE) addresses initializes both memories; cmd_ready stays low
// meanwhile. A stalled result waits in the output register; a tick that
// reaches its result while the register is still full holds until it
// drains. Both sizes must be powers of two; the block does not enforce it.
`default_nettype none

module ghb_correlation_prefetcher
  import ghb_pkg::*;
#(
  parameter int INDEX_SIZE       = GHB_INDEX_SIZE,
  parameter int HISTORY_SIZE     = GHB_HISTORY_SIZE,
  parameter int GENERATION_COUNT = GHB_GENERATION_COUNT,
  parameter int WALK_WIDTH       = GHB_WALK_WIDTH,
  parameter int WALK_DEPTH       = GHB_WALK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output      logic               cmd_ready,
  input  wire logic               command,
  input  wire logic [BLOCK_W-1:0] block_addr,
  input  wire logic               access_hit,
  input  wire logic               is_load,
  output      logic               pf_valid,
  input  wire logic               pf_ready,
  output      logic [BLOCK_W-1:0] prefetch_block
);

  localparam int IDX_W     = $clog2(INDEX_SIZE);
  localparam int HIST_W    = $clog2(HISTORY_SIZE);
  localparam int GEN_W     = (GENERATION_COUNT > 1) ? $clog2(GENERATION_COUNT) : 1;
  localparam int PTR_W     = HIST_W + GEN_W;
  localparam int WC_W      = $clog2(WALK_WIDTH + 1);
  localparam int DC_W      = (WALK_DEPTH > 1) ? $clog2(WALK_DEPTH) : 1;
  localparam int CLR_DEPTH = (INDEX_SIZE > HISTORY_SIZE) ? INDEX_SIZE : HISTORY_SIZE;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int ENTRY_W   = BLOCK_W + PTR_W;

  localparam logic [WC_W-1:0]   WC_IDLE   = WC_W'(WALK_WIDTH);
  localparam logic [DC_W-1:0]   DC_LAST   = DC_W'(WALK_DEPTH - 1);
  localparam logic [GEN_W-1:0]  GEN_LAST  = GEN_W'(GENERATION_COUNT - 1);
  localparam logic [HIST_W-1:0] SLOT_LAST = {HIST_W{1'b1}};
  localparam logic [PTR_W-1:0]  PTR_WRAP  = PTR_W'(HISTORY_SIZE - 1);
  localparam logic [PTR_W:0]    PTR_SPAN  = (PTR_W + 1)'(HISTORY_SIZE);
  localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

  // Pointer lies within one buffer length of the trigger
  function automatic logic ptr_near(input logic [PTR_W-1:0] p, input logic [PTR_W-1:0] t);
    logic [PTR_W:0] delta;
    delta = (p > t) ? ({1'b0, p} - {1'b0, t}) : ({1'b0, t} - {1'b0, p});
    return delta < PTR_SPAN;
  endfunction

  ghb_state_t state, state_next;

  logic [PTR_W-1:0]   head, head_next;
  logic [GEN_W-1:0]   gen, gen_next;
  logic [PTR_W-1:0]   wp, wp_next;
  logic [PTR_W-1:0]   dp, dp_next;
  logic [PTR_W-1:0]   tp, tp_next;
  logic [WC_W-1:0]    wc, wc_next;
  logic [DC_W-1:0]    dc, dc_next;
  logic [CLR_W-1:0]   clr, clr_next;
  logic [BLOCK_W-1:0] blk, blk_next;
  logic               pf_valid_next;
  logic [BLOCK_W-1:0] prefetch_block_next;

  logic               idx_wr_en, idx_rd_en;
  logic [IDX_W-1:0]   idx_wr_addr, idx_rd_addr;
  logic [ENTRY_W-1:0] idx_wr_data, idx_rd_data;
  logic               hist_wr_en, hist_rd_en;
  logic [HIST_W-1:0]  hist_wr_addr, hist_rd_addr;
  logic [ENTRY_W-1:0] hist_wr_data, hist_rd_data;

  logic [BLOCK_W-1:0] idx_trigger, hist_target;
  logic [PTR_W-1:0]   idx_pointer, hist_link;
  logic [PTR_W-1:0]   dp_dec, link_src;
  logic [DC_W-1:0]    dc_inc;
  logic [HIST_W-1:0]  hslot;
  logic               accept, collision, dp_ok;

  // Index table: trigger block and history pointer per hash slot
  ghb_ram #(.WIDTH(ENTRY_W), .DEPTH(INDEX_SIZE)) u_index_ram (
    .clk     (clk),
    .wr_en   (idx_wr_en),
    .wr_addr (idx_wr_addr),
    .wr_data (idx_wr_data),
    .rd_en   (idx_rd_en),
    .rd_addr (idx_rd_addr),
    .rd_data (idx_rd_data)
  );

  // History buffer: target block and link per entry
  ghb_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_SIZE)) u_history_ram (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_en   (hist_rd_en),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

  assign idx_trigger = idx_rd_data[ENTRY_W-1 -: BLOCK_W];
  assign idx_pointer = idx_rd_data[PTR_W-1:0];
  assign hist_target = hist_rd_data[ENTRY_W-1 -: BLOCK_W];
  assign hist_link   = hist_rd_data[PTR_W-1:0];

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  // Step toward older entries, wrapping pointer zero to the last slot
  assign dp_dec = (dp == '0) ? PTR_WRAP : (dp - 1'b1);
  assign dc_inc = (dc == DC_LAST) ? '0 : (dc + 1'b1);
  assign dp_ok  = ptr_near(dp, tp) && (hist_target != '0);

  // Miss link: previous occurrence, or self when the slot collides
  assign hslot     = head[HIST_W-1:0];
  assign collision = (idx_trigger != blk);
  assign link_src  = collision ? head : idx_pointer;

  // Sequencer
  always_comb begin
    state_next          = state;
    head_next           = head;
    gen_next            = gen;
    wp_next             = wp;
    dp_next             = dp;
    tp_next             = tp;
    wc_next             = wc;
    dc_next             = dc;
    clr_next            = clr;
    blk_next            = blk;
    pf_valid_next       = pf_valid && !pf_ready;
    prefetch_block_next = prefetch_block;

    idx_wr_en    = 1'b0;
    idx_wr_addr  = blk[IDX_W-1:0];
    idx_wr_data  = {blk, head};
    idx_rd_en    = 1'b0;
    idx_rd_addr  = block_addr[IDX_W-1:0];
    hist_wr_en   = 1'b0;
    hist_wr_addr = hslot;
    hist_wr_data = {blk, gen, link_src[HIST_W-1:0]};
    hist_rd_en   = 1'b0;
    hist_rd_addr = wp[HIST_W-1:0];

    unique case (state)
      S_CLEAR: begin
        // Sweep both memories to their reset contents
        idx_wr_en    = 1'b1;
        idx_wr_addr  = clr[IDX_W-1:0];
        idx_wr_data  = '0;
        hist_wr_en   = 1'b1;
        hist_wr_addr = clr[HIST_W-1:0];
        hist_wr_data = {{BLOCK_W{1'b0}}, {GEN_W{1'b0}}, clr[HIST_W-1:0]};
        clr_next     = clr + 1'b1;
        if (clr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (command) begin
            if (wc != WC_IDLE) begin
              hist_rd_en = 1'b1;
              if (dc == '0) begin
                hist_rd_addr = wp[HIST_W-1:0];
                state_next   = S_WIDE;
              end else begin
                // Current deep entry was checked on the previous tick
                hist_rd_addr = dp_dec[HIST_W-1:0];
                dp_next      = dp_dec;
                dc_next      = dc_inc;
                state_next   = S_DEEP1;
              end
            end
          end else if (!access_hit && is_load) begin
            idx_rd_en  = 1'b1;
            blk_next   = block_addr;
            state_next = S_MISS;
          end
        end
      end
      S_MISS: begin
        // Append to the history buffer and update the index slot
        idx_wr_en  = 1'b1;
        hist_wr_en = 1'b1;
        wp_next    = head;
        tp_next    = head;
        wc_next    = '0;
        dc_next    = '0;
        if (hslot == SLOT_LAST) begin
          gen_next = (gen == GEN_LAST) ? '0 : (gen + 1'b1);
        end
        head_next  = {gen_next, hslot + 1'b1};
        state_next = S_IDLE;
      end
      S_WIDE: begin
        // Follow one link, or drop the walk at an invalid or terminal entry
        if (!(ptr_near(wp, tp) && (hist_target != '0)) || (hist_link == wp)) begin
          wc_next    = WC_IDLE;
          state_next = S_IDLE;
        end else begin
          wp_next      = hist_link;
          dp_next      = hist_link;
          wc_next      = wc + 1'b1;
          hist_rd_en   = 1'b1;
          hist_rd_addr = hist_link[HIST_W-1:0];
          state_next   = S_DEEP0;
        end
      end
      S_DEEP0: begin
        // Check the linked entry, then fetch the one before it
        if (!dp_ok) begin
          dc_next    = '0;
          state_next = S_IDLE;
        end else begin
          hist_rd_en   = 1'b1;
          hist_rd_addr = dp_dec[HIST_W-1:0];
          dp_next      = dp_dec;
          dc_next      = dc_inc;
          state_next   = S_DEEP1;
        end
      end
      S_DEEP1: begin
        // Issue the older entry's block once the output register is free; end the step if that entry is not live
        if (!dp_ok) begin
          dc_next    = '0;
          state_next = S_IDLE;
        end else if (!pf_valid || pf_ready) begin
          pf_valid_next       = 1'b1;
          prefetch_block_next = hist_target;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      head     <= '0;
      gen      <= '0;
      wp       <= '0;
      dp       <= '0;
      tp       <= '0;
      wc       <= WC_IDLE;
      dc       <= '0;
      pf_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      head     <= head_next;
      gen      <= gen_next;
      wp       <= wp_next;
      dp       <= dp_next;
      tp       <= tp_next;
      wc       <= wc_next;
      dc       <= dc_next;
      pf_valid <= pf_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    blk            <= blk_next;
    prefetch_block <= prefetch_block_next;
  end

endmodule

`default_nettype wire

// ===== design/ghb_checker.sv =====
// Port-level checker for the prefetcher, bound to the top level.
`default_nettype none
`include "ghb_correlation_prefetcher_defines.svh"

module ghb_checker
  import ghb_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire logic               command,
  input wire logic               access_hit,
  input wire logic               is_load,
  input wire logic               pf_valid,
  input wire logic               pf_ready,
  input wire logic [BLOCK_W-1:0] prefetch_block
);

  logic miss_accept;

  assign miss_accept = cmd_valid && cmd_ready && !command && !access_hit && is_load;

  // Stalled result holds its value
  `GHB_ASSERT_NEXT(a_pf_hold, clk, rst, pf_valid && !pf_ready, pf_valid && $stable(prefetch_block), "stalled prefetch item changed or dropped")

  // Clearing pass blocks input right after reset
  `GHB_ASSERT_NEXT(a_clear_busy, clk, 1'b0, rst, !cmd_ready, "input accepted during memory clear")

  // A miss occupies the block for its write-back
  `GHB_ASSERT_NEXT(a_miss_busy, clk, rst, miss_accept, !cmd_ready, "miss write-back cycle skipped")

  // A new result is loaded only at the end of a walk step
  `GHB_ASSERT_SAME(a_pf_from_walk, clk, rst, $rose(pf_valid), !$past(cmd_ready), "prefetch item issued while idle")

endmodule

bind ghb_correlation_prefetcher ghb_checker u_ghb_checker (.*);

`default_nettype wire

// ===== dv/ghb_correlation_prefetcher_test.sv =====
// Self-checking testbench for the global-history-buffer correlation prefetcher.
module ghb_correlation_prefetcher_test;
  import ghb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_N  = GHB_INDEX_SIZE;
  localparam int HIST_N = GHB_HISTORY_SIZE;
  localparam int GEN_N  = GHB_GENERATION_COUNT;
  localparam int WALK_W = GHB_WALK_WIDTH;
  localparam int WALK_D = GHB_WALK_DEPTH;
  localparam int PTR_W  = $clog2(HIST_N * GEN_N);

  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N       = 23;

  typedef logic [PTR_W-1:0]   hptr_t;
  typedef logic [BLOCK_W-1:0] blk_t;

  // One directed row; quiet marks rows known to produce no prefetch
  typedef struct packed {
    logic tick;
    blk_t blk;
    logic hit;
    logic load;
    logic quiet;
  } stim_row_t;

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic cmd_valid  = 1'b0;
  logic command    = 1'b0;
  blk_t block_addr = '0;
  logic access_hit = 1'b0;
  logic is_load    = 1'b0;
  logic pf_ready   = 1'b0;
  logic cmd_ready;
  logic pf_valid;
  blk_t prefetch_block;

  // Predictor state
  blk_t       trig_tbl [IDX_N];
  hptr_t      ptr_tbl  [IDX_N];
  blk_t       hist_blk [HIST_N];
  hptr_t      hist_next[HIST_N];
  hptr_t      head_p;
  logic [1:0] gen_q;
  hptr_t      wide_p;
  hptr_t      deep_p;
  hptr_t      anchor_p;
  logic [2:0] wide_n;
  logic [2:0] deep_n;

  // Expected prefetch blocks, oldest first
  blk_t pf_expect[$];

  int err_cnt   = 0;
  int pf_seen   = 0;
  int item_cnt  = 0;
  int work_cnt  = 0;
  int tick_cnt  = 0;
  int miss_cnt  = 0;
  int wrap_cnt  = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int recv_hold = 0;
  int cyc;

  stim_row_t dir_tbl [DIR_N];
  blk_t      blk_pool[24];
  int        pat_idx [4][12];

  ghb_correlation_prefetcher u_top (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .block_addr    (block_addr),
    .access_hit    (access_hit),
    .is_load       (is_load),
    .pf_valid      (pf_valid),
    .pf_ready      (pf_ready),
    .prefetch_block(prefetch_block)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wait length for one item: 0..8, with occasional stretches of no waiting
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic blk_t rand_block();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[BLOCK_W-1:0];
  endfunction

  function automatic hptr_t form_ptr(int p);
    return hptr_t'((p % HIST_N) + int'(gen_q) * HIST_N);
  endfunction

  // Entry is live when close enough to the newest miss and holds a nonzero block
  function automatic bit hist_live(hptr_t p);
    int d;
    d = int'(p) - int'(anchor_p);
    if (d < 0) d = -d;
    if (d >= HIST_N) return 1'b0;
    return hist_blk[int'(p) % HIST_N] != '0;
  endfunction

  // Append a missing load block to the history and restart the walk at it
  function automatic void record_miss(blk_t blk);
    int    slot;
    int    hs;
    bit    collide;
    hptr_t head;
    slot    = int'(blk % IDX_N);
    collide = trig_tbl[slot] != blk;
    head    = head_p;
    hs      = int'(head) % HIST_N;
    hist_blk[hs]  = blk;
    hist_next[hs] = form_ptr(collide ? int'(head) : int'(ptr_tbl[slot]));
    trig_tbl[slot] = blk;
    ptr_tbl[slot]  = head;
    wide_p   = head;
    anchor_p = head;
    if (hs + 1 == HIST_N) begin
      gen_q = 2'((int'(gen_q) + 1) % GEN_N);
      wrap_cnt++;
    end
    head_p = form_ptr(int'(head) + 1);
    wide_n = '0;
    deep_n = '0;
  endfunction

  // One tick of the walk: follow a link wide, then step deep toward older entries
  function automatic bit step_walk(output blk_t blk);
    int slot;
    blk = '0;
    if (int'(wide_n) >= WALK_W) return 1'b0;
    if (int'(deep_n) % WALK_D == 0) begin
      slot = int'(wide_p) % HIST_N;
      if (!hist_live(wide_p) || hist_next[slot] == wide_p) begin
        wide_n = 3'(WALK_W);
        return 1'b0;
      end
      wide_p = hist_next[slot];
      wide_n = wide_n + 3'd1;
      deep_p = wide_p;
    end
    if (!hist_live(deep_p)) begin
      deep_n = '0;
      return 1'b0;
    end
    deep_p = (deep_p == '0) ? hptr_t'(HIST_N - 1) : deep_p - hptr_t'(1);
    deep_n = 3'((int'(deep_n) + 1) % WALK_D);
    if (!hist_live(deep_p)) begin
      deep_n = '0;
      return 1'b0;
    end
    blk = hist_blk[int'(deep_p) % HIST_N];
    return 1'b1;
  endfunction

  function automatic bit predict_prefetch(logic c, blk_t a, logic h, logic l,
                                          output blk_t blk);
    blk = '0;
    if (c) return step_walk(blk);
    if (h || !l) return 1'b0;
    record_miss(a);
    return 1'b0;
  endfunction

  // Present one item, hold it until accepted, then predict its result
  task automatic issue(input logic c, input blk_t a, input logic h, input logic l,
                       input logic quiet);
    int   gap;
    bit   has;
    blk_t blk;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    command    <= c;
    block_addr <= a;
    access_hit <= h;
    is_load    <= l;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    has = predict_prefetch(c, a, h, l, blk);
    if (!quiet && has) pf_expect.push_back(blk);
    item_cnt++;
    if (c) begin
      tick_cnt++;
      work_cnt++;
    end else if (!h && l) begin
      miss_cnt++;
      work_cnt++;
    end
  endtask

  // Hold the sender until every expected prefetch has drained
  task automatic drain_wait();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pf_expect.size() != 0) @(posedge clk);
  endtask

  // Check each prefetch against the oldest expectation and pace the ready
  always @(posedge clk) begin
    blk_t want;
    if (!rst) begin
      if (pf_valid && pf_ready) begin
        pf_seen++;
        if (pf_expect.size() == 0) begin
          $error("prefetch_block: expected no item, actual %h", prefetch_block);
          err_cnt++;
        end else begin
          want = pf_expect.pop_front();
          if (prefetch_block !== want) begin
            $error("prefetch_block: expected %h, actual %h", want, prefetch_block);
            err_cnt++;
          end
        end
        recv_hold = draw_wait(recv_calm);
        pf_ready <= (recv_hold == 0);
      end else if (!pf_ready) begin
        if (recv_hold > 0) recv_hold--;
        pf_ready <= (recv_hold == 0);
      end
    end
  end

  // End the run if it takes far longer than any correct run could
  initial begin
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("timeout after %0d cycles, %0d prefetches outstanding", cyc, pf_expect.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int kind;
    int p;
    int len;
    blk_t blk;

    // Predictor reset
    for (int i = 0; i < IDX_N; i++) begin
      trig_tbl[i] = '0;
      ptr_tbl[i]  = '0;
    end
    for (int i = 0; i < HIST_N; i++) begin
      hist_blk[i]  = '0;
      hist_next[i] = hptr_t'(i);
    end
    head_p   = '0;
    gen_q    = '0;
    wide_p   = '0;
    deep_p   = '0;
    anchor_p = '0;
    wide_n   = 3'(WALK_W);
    deep_n   = 3'(WALK_D);

    // Directed rows: idle walk, ignored accesses, zero block, a repeated block
    // whose chain is walked, then a hash collision that ends the chain
    dir_tbl = '{
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b1},
      '{1'b0, 58'h3FF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1},
      '{1'b0, 58'h155_5555_5555_5555, 1'b0, 1'b0, 1'b1},
      '{1'b0, 58'h2AA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b1},
      '{1'b1, 58'h3FF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1},
      '{1'b0, 58'h000_0000_0000_0000, 1'b0, 1'b1, 1'b1},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b0},
      '{1'b0, 58'h3FF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1},
      '{1'b0, 58'h155_5555_5555_5555, 1'b0, 1'b1, 1'b1},
      '{1'b0, 58'h2AA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b1},
      '{1'b0, 58'h0AB_CDEF_0123_4567, 1'b0, 1'b1, 1'b1},
      '{1'b0, 58'h2AA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b1},
      '{1'b1, 58'h3FF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b1, 1'b0},
      '{1'b1, 58'h3FF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b0},
      '{1'b1, 58'h155_5555_5555_5555, 1'b1, 1'b0, 1'b0},
      '{1'b1, 58'h2AA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b0},
      '{1'b0, 58'h000_0000_0000_01AA, 1'b0, 1'b1, 1'b1},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b0},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b0},
      '{1'b1, 58'h000_0000_0000_0000, 1'b0, 1'b0, 1'b0}
    };

    // Block pool: half the entries crowd a few hash slots to force collisions
    for (int i = 0; i < 24; i++) begin
      blk_pool[i] = rand_block();
      if (i % 2 == 1) blk_pool[i][7:0] = 8'($urandom_range(0, 7));
    end
    blk_pool[23] = '0;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 12; k++)
        pat_idx[i][k] = $urandom_range(0, 23);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < DIR_N; r++)
      issue(dir_tbl[r].tick, dir_tbl[r].blk, dir_tbl[r].hit, dir_tbl[r].load,
            dir_tbl[r].quiet);
    drain_wait();

    // Random episodes: mostly replayed miss patterns followed by ticks
    while (item_cnt < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        p   = $urandom_range(0, 3);
        len = $urandom_range(2, 12);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0)
            issue(1'b0, rand_block(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
          else
            issue(1'b0, blk_pool[pat_idx[p][k]], 1'b0, 1'b1, 1'b0);
        end
        repeat ($urandom_range(1, 8))
          issue(1'b1, rand_block(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      end else if (kind == 6) begin
        // Long run of misses to push the history buffer around
        repeat ($urandom_range(16, 40)) begin
          blk = ($urandom_range(0, 3) == 0) ? rand_block() : blk_pool[$urandom_range(0, 23)];
          issue(1'b0, blk, 1'b0, 1'b1, 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 4))
          issue(1'($urandom_range(0, 1)), rand_block(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) drain_wait();
    end

    // Drain and let any late item show up
    cmd_valid <= 1'b0;
    while (pf_expect.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Applied %0d items, %0d working (%0d ticks, %0d load misses)",
             item_cnt, work_cnt, tick_cnt, miss_cnt);
    $display("History wrapped %0d times; checked %0d prefetch items against the predictor",
             wrap_cnt, pf_seen);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ghb_pkg.sv
design/ghb_ram.sv
design/ghb_correlation_prefetcher.sv
design/ghb_checker.sv
dv/ghb_correlation_prefetcher_test.sv
